### rtl/tvsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsg_pkg
// Shared types and constants of the three-voice sound generator.
// ----------------------------------------------------------------------------
package tvsg_pkg;

	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_LATCH = 2'd3
	} tvsg_op_t;

	localparam logic [3:0] REG_TONE_LAST  = 4'd5;
	localparam logic [3:0] REG_NOISE      = 4'd6;
	localparam logic [3:0] REG_MIXER      = 4'd7;
	localparam logic [3:0] REG_AMP_A      = 4'd8;
	localparam logic [3:0] REG_AMP_B      = 4'd9;
	localparam logic [3:0] REG_AMP_C      = 4'd10;
	localparam logic [3:0] REG_ENV_FINE   = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

	localparam int NUM_REGS  = 16;
	localparam int NUM_TONES = 3;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_ENV_PREP = 2'd1,
		ST_ENV_DIV  = 2'd2,
		ST_ENV_DONE = 2'd3
	} tvsg_state_t;

	typedef struct packed {
		logic take;
		logic env_prep;
		logic div_step;
		logic env_done;
	} tvsg_cmd_t;

	typedef struct packed {
		logic env_tick;
		logic div_last;
		logic out_full;
	} tvsg_status_t;

endpackage

### rtl/tvsg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsg_if
// Request and response channels of the three-voice sound generator.
// ----------------------------------------------------------------------------
interface tvsg_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       reset_n;
	logic [7:0] data_in;

	modport source (output valid, output operation, output reset_n, output data_in,
		input ready);
	modport sink (input valid, input operation, input reset_n, input data_in,
		output ready);
endinterface

interface tvsg_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_valid;
	logic [9:0] sample;
	logic       sample_valid;

	modport source (output valid, output read_data, output read_valid, output sample,
		output sample_valid, input ready);
	modport sink (input valid, input read_data, input read_valid, input sample,
		input sample_valid, output ready);
endinterface

### rtl/tvsg_env_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsg_env_div
// Restoring divider giving the four-bit envelope step, one bit a cycle.
// ----------------------------------------------------------------------------
module tvsg_env_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [16:0] numer,
	input  logic [16:0] span,
	output logic [3:0]  quot,
	output logic        last
);
	logic [16:0] rem_q;
	logic [3:0]  quot_q;
	logic [1:0]  cnt_q;
	logic [17:0] shifted;
	logic        fits;

	// The numerator is below the span, so four steps give the whole quotient.
	always_comb begin
		shifted = {rem_q, 1'b0};
		fits    = shifted >= {1'b0, span};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (start) begin
			cnt_q <= 2'd0;
		end else if (step) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= numer;
			quot_q <= 4'd0;
		end else if (step) begin
			rem_q  <= fits ? 17'(shifted - {1'b0, span}) : shifted[16:0];
			quot_q <= {quot_q[2:0], fits};
		end
	end

	assign quot = quot_q;
	assign last = (cnt_q == 2'd3);
endmodule

### rtl/tvsg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsg_datapath
// Register file, tone, noise and envelope generators, mixer and result register.
// ----------------------------------------------------------------------------
module tvsg_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tvsg_pkg::tvsg_cmd_t   cmd,
	output tvsg_pkg::tvsg_status_t status,
	input  logic [1:0]            operation,
	input  logic                  reset_n,
	input  logic [7:0]            data_in,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [7:0]            read_data,
	output logic                  read_valid,
	output logic [9:0]            sample,
	output logic                  sample_valid
);
	import tvsg_pkg::*;

	logic [7:0]  regf_q [NUM_REGS];
	logic [7:0]  sel_q;
	logic [11:0] tper_q [NUM_TONES];
	logic [11:0] tcnt_q [NUM_TONES];
	logic [2:0]  tlvl_q;
	logic [4:0]  nper_q;
	logic [4:0]  ncnt_q;
	logic [16:0] nsh_q;
	logic        nlvl_q;
	logic [3:0]  cpre_q;
	logic [3:0]  epre_q;
	logic [16:0] erem_q;
	logic [1:0]  ecyc_q;
	logic [3:0]  elvl_q;

	logic        out_valid_q;
	logic [7:0]  out_rd_q;
	logic        out_rv_q;
	logic [9:0]  out_smp_q;
	logic        out_sv_q;

	logic [7:0]  regf_w [NUM_REGS];
	logic [11:0] tper_w [NUM_TONES];
	logic [11:0] tcnt_n [NUM_TONES];
	logic [2:0]  tlvl_n;
	logic [4:0]  nper_w;
	logic [4:0]  ncnt_n;
	logic [16:0] nsh_n;
	logic        nlvl_n;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic        env_restart;
	logic        tick;
	logic [3:0]  elvl_w;
	logic [9:0]  sample_w;
	logic [7:0]  rd_w;
	logic [16:0] span;
	logic [16:0] rem_p;
	logic [1:0]  cyc_p;
	logic [16:0] elapsed;
	logic [3:0]  quot;
	logic        div_last;
	logic [3:0]  lvl_d;
	logic [9:0]  sample_d;

	function automatic logic [9:0] mix_sample(input logic [7:0] en, input logic [2:0] tl,
		input logic nl, input logic [23:0] amps, input logic [3:0] el);
		logic [1:0] m;
		logic [3:0] g;
		logic [7:0] a;
		logic [5:0] prod;
		logic [6:0] sum;
		sum = 7'd0;
		for (int ch = 0; ch < NUM_TONES; ch++) begin
			a    = amps[8*ch +: 8];
			m    = {1'b0, ~en[ch] & tl[ch]} + {1'b0, ~en[ch+3] & nl};
			g    = a[4] ? el : a[3:0];
			prod = 6'(m) * 6'(g);
			sum  = sum + 7'(prod);
		end
		return ({3'b0, sum} << 3) + ({3'b0, sum} << 1);
	endfunction

	function automatic logic [3:0] env_level(input logic [1:0] cyc, input logic [3:0] shape,
		input logic [3:0] stp);
		logic cont;
		logic attack;
		logic alt;
		logic hold;
		cont   = shape[3];
		attack = shape[2];
		alt    = shape[1];
		hold   = shape[0];
		if (cyc == 2'd1) begin
			return attack ? stp : ~stp;
		end else if (!cont) begin
			return 4'd0;
		end else if (hold) begin
			return (alt ^ attack) ? 4'd15 : 4'd0;
		end else if (!alt) begin
			return attack ? stp : ~stp;
		end
		return (~cyc[0] ^ attack) ? stp : ~stp;
	endfunction

	always_comb begin
		logic [11:0] per;
		logic [11:0] tcnt_w;
		logic [11:0] tdec;
		logic [4:0]  ncnt_w;
		logic [4:0]  ndec;
		wr_en       = (operation == OP_WRITE) && (sel_q[7:4] == 4'd0);
		wr_addr     = sel_q[3:0];
		env_restart = wr_en && (wr_addr == REG_ENV_SHAPE);
		tick        = (cpre_q == 4'hF);
		for (int i = 0; i < NUM_REGS; i++) begin
			regf_w[i] = (wr_en && (wr_addr == 4'(i))) ? data_in : regf_q[i];
		end
		tlvl_n = tlvl_q;
		for (int ch = 0; ch < NUM_TONES; ch++) begin
			per = {regf_w[2*ch+1][3:0], regf_w[2*ch]};
			if (per == 12'd0) begin
				per = 12'd1;
			end
			if (wr_en && (wr_addr <= REG_TONE_LAST) && (wr_addr[3:1] == 3'(ch))) begin
				tper_w[ch] = per;
				tcnt_w     = per;
			end else begin
				tper_w[ch] = tper_q[ch];
				tcnt_w     = tcnt_q[ch];
			end
			tdec = tcnt_w - 12'd1;
			if (!tick) begin
				tcnt_n[ch] = tcnt_w;
			end else if (tdec == 12'd0) begin
				tcnt_n[ch] = tper_w[ch];
				tlvl_n[ch] = ~tlvl_q[ch];
			end else begin
				tcnt_n[ch] = tdec;
			end
		end
		if (wr_en && (wr_addr == REG_NOISE)) begin
			nper_w = (regf_w[REG_NOISE][4:0] == 5'd0) ? 5'd1 : regf_w[REG_NOISE][4:0];
			ncnt_w = nper_w;
		end else begin
			nper_w = nper_q;
			ncnt_w = ncnt_q;
		end
		ndec   = ncnt_w - 5'd1;
		nsh_n  = nsh_q;
		nlvl_n = nlvl_q;
		if (!tick) begin
			ncnt_n = ncnt_w;
		end else if (ndec == 5'd0) begin
			ncnt_n = nper_w;
			nsh_n  = {nsh_q[0] ^ nsh_q[3], nsh_q[16:1]};
			nlvl_n = nsh_q[1];
		end else begin
			ncnt_n = ndec;
		end
		elvl_w   = env_restart ? 4'd0 : elvl_q;
		sample_w = tick ? mix_sample(regf_w[REG_MIXER], tlvl_n, nlvl_n,
			{regf_w[REG_AMP_C], regf_w[REG_AMP_B], regf_w[REG_AMP_A]}, elvl_w) : 10'd0;
		rd_w = 8'd0;
		if ((operation == OP_READ) && (sel_q[7:4] == 4'd0)) begin
			rd_w = regf_q[sel_q[3:0]];
		end
	end

	always_comb begin
		logic [16:0] rem_dec;
		span    = {1'b0, regf_q[REG_ENV_COARSE], regf_q[REG_ENV_FINE]} + 17'd1;
		rem_dec = erem_q - 17'd1;
		rem_p   = rem_dec;
		cyc_p   = ecyc_q;
		if (rem_dec == 17'd0) begin
			rem_p = span;
			case (ecyc_q)
				2'd0:    cyc_p = 2'd1;
				2'd1:    cyc_p = 2'd2;
				2'd2:    cyc_p = 2'd3;
				default: cyc_p = 2'd2;
			endcase
		end
		elapsed  = (rem_p > span) ? 17'd0 : 17'(span - rem_p);
		lvl_d    = env_level(ecyc_q, regf_q[REG_ENV_SHAPE][3:0], quot);
		sample_d = mix_sample(regf_q[REG_MIXER], tlvl_q, nlvl_q,
			{regf_q[REG_AMP_C], regf_q[REG_AMP_B], regf_q[REG_AMP_A]}, lvl_d);
	end

	tvsg_env_div u_env_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.env_prep),
		.step   (cmd.div_step),
		.numer  (elapsed),
		.span   (span),
		.quot   (quot),
		.last   (div_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regf_q[i] <= 8'd0;
			end
			sel_q <= 8'd0;
			for (int ch = 0; ch < NUM_TONES; ch++) begin
				tper_q[ch] <= 12'd4095;
				tcnt_q[ch] <= 12'd1;
			end
			tlvl_q <= 3'd0;
			nper_q <= 5'd31;
			ncnt_q <= 5'd1;
			nsh_q  <= 17'd1;
			nlvl_q <= 1'b0;
			cpre_q <= 4'd0;
			epre_q <= 4'd0;
			erem_q <= 17'd1;
			ecyc_q <= 2'd0;
			elvl_q <= 4'd0;
		end else if (cmd.take && !reset_n) begin
			sel_q <= 8'd0;
			for (int ch = 0; ch < NUM_TONES; ch++) begin
				tper_q[ch] <= 12'd4095;
				tcnt_q[ch] <= 12'd1;
			end
			tlvl_q <= 3'd0;
			nper_q <= 5'd31;
			ncnt_q <= 5'd1;
			nsh_q  <= 17'd1;
			nlvl_q <= 1'b0;
			erem_q <= 17'd1;
			ecyc_q <= 2'd0;
			elvl_q <= 4'd0;
		end else if (cmd.take) begin
			regf_q <= regf_w;
			if (operation == OP_LATCH) begin
				sel_q <= data_in;
			end
			tper_q <= tper_w;
			tcnt_q <= tcnt_n;
			tlvl_q <= tlvl_n;
			nper_q <= nper_w;
			ncnt_q <= ncnt_n;
			nsh_q  <= nsh_n;
			nlvl_q <= nlvl_n;
			cpre_q <= cpre_q + 4'd1;
			if (tick) begin
				epre_q <= epre_q + 4'd1;
			end
			if (env_restart) begin
				erem_q <= 17'd1;
				ecyc_q <= 2'd0;
			end
			elvl_q <= elvl_w;
		end else if (cmd.env_prep) begin
			erem_q <= rem_p;
			ecyc_q <= cyc_p;
		end else if (cmd.env_done) begin
			elvl_q <= lvl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && !status.env_tick) || cmd.env_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			out_rd_q  <= reset_n ? rd_w : 8'd0;
			out_rv_q  <= reset_n && (operation == OP_READ);
			out_smp_q <= reset_n ? sample_w : 10'd0;
			out_sv_q  <= reset_n && tick;
		end else if (cmd.env_done) begin
			out_smp_q <= sample_d;
			out_sv_q  <= 1'b1;
		end
	end

	assign status.env_tick = reset_n && (cpre_q == 4'hF) && (epre_q == 4'hF);
	assign status.div_last = div_last;
	assign status.out_full = out_valid_q;

	assign out_valid    = out_valid_q;
	assign read_data    = out_rd_q;
	assign read_valid   = out_rv_q;
	assign sample       = out_smp_q;
	assign sample_valid = out_sv_q;
endmodule

### rtl/tvsg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsg_ctrl
// Controller sequencing request intake and the multi-cycle envelope update.
// ----------------------------------------------------------------------------
module tvsg_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_ready,
	input  tvsg_pkg::tvsg_status_t status,
	output tvsg_pkg::tvsg_cmd_t    cmd
);
	import tvsg_pkg::*;

	tvsg_state_t state_q;
	tvsg_state_t state_d;
	logic        slot_free;

	assign slot_free = !status.out_full || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && slot_free && status.env_tick) begin
					state_d = ST_ENV_PREP;
				end
			end
			ST_ENV_PREP: begin
				state_d = ST_ENV_DIV;
			end
			ST_ENV_DIV: begin
				if (status.div_last) begin
					state_d = ST_ENV_DONE;
				end
			end
			ST_ENV_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = slot_free;
				cmd.take = in_valid && slot_free;
			end
			ST_ENV_PREP: begin
				cmd.env_prep = 1'b1;
			end
			ST_ENV_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_ENV_DONE: begin
				cmd.env_done = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

### rtl/three_voice_sound_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_sound_generator
// Three tone channels, a noise source and an envelope behind a byte bus.
// ----------------------------------------------------------------------------
// Each request on the request channel is one chip clock: a bus operation
// (idle, read, write, address latch), a generator reset bit and a data byte.
// Every request yields exactly one item on the response channel, carrying
// read data and, on every sixteenth non-reset clock, a mixed sample.
// A response to a request without an envelope step appears in the cycle
// after the request is accepted, and a new request is taken every cycle while
// the controller is idle and the response register is free or being emptied.
// On every 256th non-reset clock the envelope also advances: the controller
// then updates the envelope counter (ST_ENV_PREP), runs the bit-serial step
// divider (ST_ENV_DIV) and forms the mix (ST_ENV_DONE) before that request's
// response appears and before the next request is accepted.
// When the receiver stalls, the response register holds its item and the
// request channel is held off until it is taken.
// The asynchronous reset clears the register file, the prescalers and all
// generator state. A request with reset_n low resets the generators and the
// selected address only and returns an all-zero response.
// ----------------------------------------------------------------------------
module three_voice_sound_generator (
	input  logic       clk,
	input  logic       arst_n,
	tvsg_req_if.sink   request,
	tvsg_rsp_if.source response
);
	import tvsg_pkg::*;

	tvsg_cmd_t    cmd;
	tvsg_status_t status;

	tvsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_ready (response.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tvsg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (request.operation),
		.reset_n      (request.reset_n),
		.data_in      (request.data_in),
		.out_ready    (response.ready),
		.out_valid    (response.valid),
		.read_data    (response.read_data),
		.read_valid   (response.read_valid),
		.sample       (response.sample),
		.sample_valid (response.sample_valid)
	);
endmodule

### rtl/tvsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsg_port_checker
// Port-level assertions for the three-voice sound generator.
// ----------------------------------------------------------------------------
module tvsg_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_data,
	input logic       read_valid,
	input logic [9:0] sample,
	input logic       sample_valid
);
	// A request is only taken when the response slot can accept its result.
	a_intake_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> !(rsp_valid && !rsp_ready))
		else $error("request accepted while response is stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response dropped while stalled");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !read_valid) |-> (read_data == 8'd0))
		else $error("read data set without a read");

	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !sample_valid) |-> (sample == 10'd0))
		else $error("sample set without a sample clock");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && sample_valid) |-> (sample <= 10'd900))
		else $error("sample out of range");
endmodule

bind three_voice_sound_generator tvsg_port_checker u_tvsg_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (request.valid),
	.req_ready    (request.ready),
	.rsp_valid    (response.valid),
	.rsp_ready    (response.ready),
	.read_data    (response.read_data),
	.read_valid   (response.read_valid),
	.sample       (response.sample),
	.sample_valid (response.sample_valid)
);
